// ----- rtl/sphq_pkg.sv -----
// shared types and constants for the stable priority heap queue
package sphq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ORDER_BITS  = 8;
    localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int TASK_IDS    = 16;
    localparam int TASK_BITS   = 4;
    localparam int PRIO_BITS   = 8;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_NOT_QUEUED = 2'd3
    } t_status;

    // one heap slot as stored in memory
    typedef struct packed {
        logic [TASK_BITS-1:0]  task_id;
        logic [PRIO_BITS-1:0]  prio;
        logic [ORDER_BITS-1:0] order;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS_RD,
        S_LAST_RD,
        S_PLACE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_ROOT_RD,
        S_ROOT_WAIT,
        S_OUT
    } t_state;

    // true when entry a wins over entry b under the running minimum order m
    function automatic logic beats(input t_entry a, input t_entry b,
                                   input logic [ORDER_BITS-1:0] m);
        logic a_old;
        logic b_old;
        begin
            a_old = (a.order >= m);
            b_old = (b.order >= m);
            if (a.prio != b.prio) begin
                beats = (a.prio < b.prio);
            end else if (a_old != b_old) begin
                beats = a_old;
            end else begin
                beats = (a.order < b.order);
            end
        end
    endfunction

endpackage

// ----- rtl/stable_priority_heap_queue.sv -----
// top level: heap priority queue with memory-held slots and a sift sequencer
//
//  channel | direction | signals
//  --------+-----------+----------------------------------------------------
//  input   | in        | i_valid, o_ready, i_command, i_task_id, i_priority_req
//  output  | out       | o_valid, i_ready, o_status, o_top_task, o_top_priority,
//          |           | o_queue_count, o_queue_empty
//
// one beat at a time: accepted only in idle, result held until taken
// a rejected, duplicate or unused command only reads the root; an insert sifts up;
// a pop moves the last entry to the root and sifts it down; a remove of the last
// slot just drops it, otherwise the last entry fills the hole and sifts up, or down
// if it does not move up
// the heap slots and the task position map are memories with registered read data
// reset clears the count, the order counters and the per-task queued flags;
// the memories need no clearing since every entry is written before read
// a stalled result stops the sequencer in its output state
module stable_priority_heap_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [3:0] i_task_id,
    input  logic [7:0] i_priority_req,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [3:0] o_top_task,
    output logic [7:0] o_top_priority,
    output logic [4:0] o_queue_count,
    output logic       o_queue_empty
);

    localparam int SB = sphq_pkg::SLOT_BITS;
    localparam int CB = sphq_pkg::COUNT_BITS;
    localparam int OB = sphq_pkg::ORDER_BITS;

    // heap slot memory and task position memory
    sphq_pkg::t_entry       heap_mem [sphq_pkg::QUEUE_DEPTH];
    logic [SB-1:0]          pos_mem  [sphq_pkg::TASK_IDS];

    sphq_pkg::t_entry       r_rd_data;
    logic [SB-1:0]          r_pos_data;

    logic                   mem_rd_en;
    logic [SB-1:0]          mem_rd_addr;
    logic                   mem_wr_en;
    logic [SB-1:0]          mem_wr_addr;
    sphq_pkg::t_entry       mem_wr_data;
    logic                   pos_wr_en;
    logic [3:0]             pos_wr_addr;
    logic [SB-1:0]          pos_wr_data;

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            heap_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= heap_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_wr_en) begin
            pos_mem[pos_wr_addr] <= pos_wr_data;
        end
        r_pos_data <= pos_mem[i_task_id];
    end

    // control and working registers
    sphq_pkg::t_state       r_state, n_state;
    logic [CB-1:0]          r_count, n_count;
    logic [OB-1:0]          r_next_order, n_next_order;
    logic [OB-1:0]          r_oldest, n_oldest;
    logic [15:0]            r_queued, n_queued;
    sphq_pkg::t_cmd         r_cmd, n_cmd;
    logic [3:0]             r_tid, n_tid;
    logic [7:0]             r_prio, n_prio;
    sphq_pkg::t_status      r_status, n_status;
    // the moving entry is held here, written only when it settles
    sphq_pkg::t_entry       r_cur, n_cur;
    logic [SB-1:0]          r_idx, n_idx;
    sphq_pkg::t_entry       r_left, n_left;
    logic                   r_up_done, n_up_done;
    sphq_pkg::t_entry       r_root, n_root;

    logic [SB-1:0]          parent_idx;
    logic [SB:0]            left_idx_w;
    logic [SB:0]            right_idx_w;
    logic                   left_ok;
    logic                   right_ok;
    logic [SB-1:0]          last_idx;

    assign parent_idx  = SB'((r_idx - 1'b1) >> 1);
    assign left_idx_w  = {r_idx, 1'b1};
    assign right_idx_w = (SB+1)'({r_idx, 1'b1}) + 1'b1;
    assign left_ok     = ({1'b0, left_idx_w} < (SB+2)'(r_count));
    assign right_ok    = ({1'b0, right_idx_w} < (SB+2)'(r_count));
    assign last_idx    = SB'(r_count - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sphq_pkg::S_IDLE;
            r_count      <= '0;
            r_next_order <= '0;
            r_oldest     <= '0;
            r_queued     <= '0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_next_order <= n_next_order;
            r_oldest     <= n_oldest;
            r_queued     <= n_queued;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_tid       <= n_tid;
        r_prio      <= n_prio;
        r_status    <= n_status;
        r_cur       <= n_cur;
        r_idx       <= n_idx;
        r_left      <= n_left;
        r_up_done   <= n_up_done;
        r_root      <= n_root;
    end

    // next state and datapath
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_next_order = r_next_order;
        n_oldest     = r_oldest;
        n_queued     = r_queued;
        n_cmd        = r_cmd;
        n_tid        = r_tid;
        n_prio       = r_prio;
        n_status     = r_status;
        n_cur        = r_cur;
        n_idx        = r_idx;
        n_left       = r_left;
        n_up_done    = r_up_done;
        n_root       = r_root;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = '0;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = '0;
        mem_wr_data  = r_cur;
        pos_wr_en    = 1'b0;
        pos_wr_addr  = r_cur.task_id;
        pos_wr_data  = r_idx;
        unique case (r_state)
            sphq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = sphq_pkg::t_cmd'(i_command);
                    n_tid    = i_task_id;
                    n_prio   = i_priority_req;
                    n_status = sphq_pkg::ST_OK;
                    // position map read happens in parallel for a remove
                    n_state  = sphq_pkg::S_POS_RD;
                end
            end
            sphq_pkg::S_POS_RD: begin
                n_state = sphq_pkg::S_ROOT_RD;
                unique case (r_cmd)
                    sphq_pkg::CMD_INSERT: begin
                        if (r_count >= CB'(sphq_pkg::QUEUE_DEPTH)) begin
                            n_status = sphq_pkg::ST_FULL;
                        end else if (!r_queued[r_tid]) begin
                            n_cur.task_id = r_tid;
                            n_cur.prio    = r_prio;
                            n_cur.order   = r_next_order;
                            n_next_order  = r_next_order + 1'b1;
                            n_queued[r_tid] = 1'b1;
                            n_idx     = SB'(r_count);
                            n_count   = r_count + 1'b1;
                            n_up_done = 1'b1;
                            n_state   = sphq_pkg::S_UP_RD;
                        end
                    end
                    sphq_pkg::CMD_POP: begin
                        if (r_count == '0) begin
                            n_status = sphq_pkg::ST_EMPTY;
                        end else begin
                            n_idx       = '0;
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = '0;
                            n_state     = sphq_pkg::S_LAST_RD;
                        end
                    end
                    sphq_pkg::CMD_REMOVE: begin
                        if (!r_queued[r_tid] || r_count == '0 ||
                            CB'(r_pos_data) >= r_count) begin
                            n_status = sphq_pkg::ST_NOT_QUEUED;
                        end else begin
                            n_idx       = r_pos_data;
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = r_pos_data;
                            n_state     = sphq_pkg::S_LAST_RD;
                        end
                    end
                    sphq_pkg::CMD_NOP: begin
                        n_status = sphq_pkg::ST_OK;
                    end
                endcase
            end
            sphq_pkg::S_LAST_RD: begin
                // r_rd_data is the leaving entry
                n_queued[r_rd_data.task_id] = 1'b0;
                if (r_cmd == sphq_pkg::CMD_POP && r_rd_data.order == r_oldest) begin
                    n_oldest = r_oldest + 1'b1;
                end
                n_count     = r_count - 1'b1;
                mem_rd_en   = 1'b1;
                mem_rd_addr = last_idx;
                n_state     = sphq_pkg::S_PLACE;
            end
            sphq_pkg::S_PLACE: begin
                // r_count is already the shrunken count
                n_cur = r_rd_data;
                if (CB'(r_idx) >= r_count) begin
                    n_state = sphq_pkg::S_ROOT_RD;
                end else begin
                    n_up_done = 1'b0;
                    n_state   = sphq_pkg::S_UP_RD;
                end
            end
            sphq_pkg::S_UP_RD: begin
                if (r_idx == '0) begin
                    n_state = r_up_done ? sphq_pkg::S_ROOT_RD : sphq_pkg::S_DN_RDL;
                    if (r_up_done) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_idx;
                        pos_wr_en   = 1'b1;
                    end
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = parent_idx;
                    n_state     = sphq_pkg::S_UP_CMP;
                end
            end
            sphq_pkg::S_UP_CMP: begin
                if (sphq_pkg::beats(r_cur, r_rd_data, r_oldest)) begin
                    // parent moves down into the hole
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_idx;
                    mem_wr_data = r_rd_data;
                    pos_wr_en   = 1'b1;
                    pos_wr_addr = r_rd_data.task_id;
                    pos_wr_data = r_idx;
                    n_idx       = parent_idx;
                    n_up_done   = 1'b1;
                    n_state     = sphq_pkg::S_UP_RD;
                end else if (r_up_done) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_idx;
                    pos_wr_en   = 1'b1;
                    n_state     = sphq_pkg::S_ROOT_RD;
                end else begin
                    n_state = sphq_pkg::S_DN_RDL;
                end
            end
            sphq_pkg::S_DN_RDL: begin
                if (!left_ok) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_idx;
                    pos_wr_en   = 1'b1;
                    n_state     = sphq_pkg::S_ROOT_RD;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = SB'(left_idx_w);
                    n_state     = sphq_pkg::S_DN_RDR;
                end
            end
            sphq_pkg::S_DN_RDR: begin
                n_left      = r_rd_data;
                mem_rd_en   = right_ok;
                mem_rd_addr = SB'(right_idx_w);
                n_state     = sphq_pkg::S_DN_CMP;
            end
            sphq_pkg::S_DN_CMP: begin
                priority if (right_ok && sphq_pkg::beats(r_rd_data, r_left, r_oldest)
                             && sphq_pkg::beats(r_rd_data, r_cur, r_oldest)) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_idx;
                    mem_wr_data = r_rd_data;
                    pos_wr_en   = 1'b1;
                    pos_wr_addr = r_rd_data.task_id;
                    n_idx       = SB'(right_idx_w);
                    n_state     = sphq_pkg::S_DN_RDL;
                end else if (sphq_pkg::beats(r_left, r_cur, r_oldest)) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_idx;
                    mem_wr_data = r_left;
                    pos_wr_en   = 1'b1;
                    pos_wr_addr = r_left.task_id;
                    n_idx       = SB'(left_idx_w);
                    n_state     = sphq_pkg::S_DN_RDL;
                end else begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_idx;
                    pos_wr_en   = 1'b1;
                    n_state     = sphq_pkg::S_ROOT_RD;
                end
            end
            sphq_pkg::S_ROOT_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                n_state     = sphq_pkg::S_ROOT_WAIT;
            end
            sphq_pkg::S_ROOT_WAIT: begin
                n_root  = r_rd_data;
                n_state = sphq_pkg::S_OUT;
            end
            sphq_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = sphq_pkg::S_IDLE;
                end
            end
            default: n_state = sphq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready        = (r_state == sphq_pkg::S_IDLE);
        o_valid        = (r_state == sphq_pkg::S_OUT);
        o_status       = r_status;
        o_queue_count  = r_count;
        o_queue_empty  = (r_count == '0);
        o_top_task     = (r_count == '0) ? '0 : r_root.task_id;
        o_top_priority = (r_count == '0) ? '0 : r_root.prio;
    end

    // assertions
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(sphq_pkg::QUEUE_DEPTH))
        else $error("count beyond depth");
    a_queued_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sphq_pkg::S_IDLE) |-> ($countones(r_queued) == 32'(r_count)))
        else $error("queued flags disagree with count");
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_queue_empty == (o_queue_count == '0)))
        else $error("empty flag mismatch");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)))
        else $error("result dropped while stalled");

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for the stable priority heap queue: heap predictor, scoreboard, random traffic
`timescale 1ns / 100ps

// predicted heap state and the queue of results still awaited
class heap_scoreboard;
    logic [3:0]  slot_task [16];
    logic [7:0]  slot_prio [16];
    logic [7:0]  slot_order [16];
    logic [3:0]  task_slot [16];
    bit          task_held [16];
    int unsigned held_count;
    logic [7:0]  next_order;
    logic [7:0]  oldest_order;
    logic [19:0] pending_results [$];
    int          mismatch_count;

    function new();
        held_count = 0;
        next_order = 0;
        oldest_order = 0;
        mismatch_count = 0;
        foreach (task_held[k]) task_held[k] = 0;
    endfunction

    // earlier insertion under the wrapping order, measured from oldest_order
    function bit order_earlier(logic [7:0] a, logic [7:0] b);
        if (oldest_order > a && oldest_order <= b) return 0;
        if (oldest_order > b && oldest_order <= a) return 1;
        return a < b;
    endfunction

    function bit slot_wins(int i, int j);
        if (slot_prio[i] != slot_prio[j]) return slot_prio[i] < slot_prio[j];
        return order_earlier(slot_order[i], slot_order[j]);
    endfunction

    function void swap_slots(int i, int j);
        logic [3:0] t;
        logic [7:0] p;
        logic [7:0] o;
        t = slot_task[i]; p = slot_prio[i]; o = slot_order[i];
        slot_task[i] = slot_task[j]; slot_prio[i] = slot_prio[j];
        slot_order[i] = slot_order[j];
        slot_task[j] = t; slot_prio[j] = p; slot_order[j] = o;
        task_slot[slot_task[i]] = 4'(i);
        task_slot[slot_task[j]] = 4'(j);
    endfunction

    function void sift_up(int i);
        while (i > 0 && slot_wins(i, (i - 1) / 2)) begin
            swap_slots(i, (i - 1) / 2);
            i = (i - 1) / 2;
        end
    endfunction

    function void sift_down(int i);
        int best;
        forever begin
            best = i;
            if (2 * i + 1 < held_count && slot_wins(2 * i + 1, best)) best = 2 * i + 1;
            if (2 * i + 2 < held_count && slot_wins(2 * i + 2, best)) best = 2 * i + 2;
            if (best == i) break;
            swap_slots(i, best);
            i = best;
        end
    endfunction

    // last entry fills the freed slot, then settles both ways
    function void vacate_slot(int i);
        int last;
        last = held_count - 1;
        task_held[slot_task[i]] = 0;
        if (i != last) begin
            slot_task[i] = slot_task[last];
            slot_prio[i] = slot_prio[last];
            slot_order[i] = slot_order[last];
            task_slot[slot_task[i]] = 4'(i);
        end
        held_count = last;
        if (i < held_count) begin
            sift_up(i);
            sift_down(i);
        end
    endfunction

    function void note_command(sphq_pkg::t_cmd cmd, logic [3:0] tid, logic [7:0] prio);
        sphq_pkg::t_status st;
        logic [7:0] popped;
        st = sphq_pkg::ST_OK;
        case (cmd)
            sphq_pkg::CMD_INSERT: begin
                if (held_count >= 16) begin
                    st = sphq_pkg::ST_FULL;
                end else if (!task_held[tid]) begin
                    slot_task[held_count] = tid;
                    slot_prio[held_count] = prio;
                    slot_order[held_count] = next_order;
                    next_order++;
                    task_slot[tid] = 4'(held_count);
                    task_held[tid] = 1;
                    held_count++;
                    sift_up(held_count - 1);
                end
            end
            sphq_pkg::CMD_POP: begin
                if (held_count == 0) begin
                    st = sphq_pkg::ST_EMPTY;
                end else begin
                    popped = slot_order[0];
                    vacate_slot(0);
                    if (popped == oldest_order) oldest_order++;
                end
            end
            sphq_pkg::CMD_REMOVE: begin
                if (!task_held[tid] || held_count == 0 || task_slot[tid] >= held_count)
                    st = sphq_pkg::ST_NOT_QUEUED;
                else
                    vacate_slot(task_slot[tid]);
            end
            default: ;
        endcase
        if (held_count == 0)
            pending_results.push_back({st, 4'd0, 8'd0, 5'd0, 1'b1});
        else
            pending_results.push_back({st, slot_task[0], slot_prio[0],
                                       5'(held_count), 1'b0});
    endfunction

    function void check_result(logic [19:0] got);
        logic [19:0] want;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result beat %h", got);
            return;
        end
        want = pending_results.pop_front();
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch want %h %h %h %h %h got %h %h %h %h %h",
                         want[19:18], want[17:14], want[13:6], want[5:1], want[0],
                         got[19:18], got[17:14], got[13:6], got[5:1], got[0]);
        end
    endfunction
endclass

module testbench;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_command;
    logic [3:0] i_task_id;
    logic [7:0] i_priority_req;
    logic       o_valid;
    logic       i_ready;
    logic [1:0] o_status;
    logic [3:0] o_top_task;
    logic [7:0] o_top_priority;
    logic [4:0] o_queue_count;
    logic       o_queue_empty;

    heap_scoreboard heap_model;
    bit  stimulus_done;
    bit  calm_phase;   // no idling on either side while set
    int  idle_pct;

    stable_priority_heap_queue dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // predict on every accepted input beat, check every accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            heap_model.note_command(sphq_pkg::t_cmd'(i_command), i_task_id, i_priority_req);
        if (i_rst_n && o_valid && i_ready)
            heap_model.check_result({o_status, o_top_task, o_top_priority,
                                     o_queue_count, o_queue_empty});
    end

    // receiver stalls at random, except in the calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 0;
        else i_ready <= calm_phase || ($urandom_range(99) >= idle_pct);
    end

    // present one beat and hold it until accepted; idle a random gap first
    task automatic send_command(sphq_pkg::t_cmd cmd, logic [3:0] tid, logic [7:0] prio);
        while (!calm_phase && $urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_command <= cmd;
        i_task_id <= tid;
        i_priority_req <= prio;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // mostly inserts and pops with a sprinkling of removes and the unused code
    task automatic send_random();
        int r;
        logic [7:0] prio;
        r = $urandom_range(99);
        // narrow priorities often, so ties and the order rule get exercised
        prio = ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom);
        if (r < 45) send_command(sphq_pkg::CMD_INSERT, 4'($urandom), prio);
        else if (r < 75) send_command(sphq_pkg::CMD_POP, 4'($urandom), 8'($urandom));
        else if (r < 95) send_command(sphq_pkg::CMD_REMOVE, 4'($urandom), 8'($urandom));
        else send_command(sphq_pkg::CMD_NOP, 4'($urandom), 8'($urandom));
    endtask

    initial begin
        heap_model = new();
        stimulus_done = 0;
        calm_phase = 0;
        idle_pct = 27;
        i_rst_n = 0;
        i_valid = 0;
        i_command = sphq_pkg::CMD_NOP;
        i_task_id = 0;
        i_priority_req = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty pop and remove, fill with extremes and ties, overflow
        send_command(sphq_pkg::CMD_POP, 4'd0, 8'd0);
        send_command(sphq_pkg::CMD_REMOVE, 4'd15, 8'd0);
        send_command(sphq_pkg::CMD_INSERT, 4'd15, 8'd255);
        send_command(sphq_pkg::CMD_INSERT, 4'd15, 8'd0);    // already queued
        send_command(sphq_pkg::CMD_INSERT, 4'd0, 8'd0);
        send_command(sphq_pkg::CMD_INSERT, 4'd1, 8'd0);     // tie with task 0
        for (int k = 2; k < 16; k++)
            send_command(sphq_pkg::CMD_INSERT, 4'(k), 8'(k % 3 * 100));
        send_command(sphq_pkg::CMD_INSERT, 4'd5, 8'd1);     // full
        send_command(sphq_pkg::CMD_REMOVE, 4'd15, 8'd0);
        send_command(sphq_pkg::CMD_REMOVE, 4'd15, 8'd0);    // not queued
        send_command(sphq_pkg::CMD_NOP, 4'd7, 8'd7);
        send_command(sphq_pkg::CMD_POP, 4'd0, 8'd0);
        send_command(sphq_pkg::CMD_POP, 4'd0, 8'd0);

        // random traffic; long run keeps the order counter wrapping
        for (int n = 0; n < 1200; n++) begin
            calm_phase = (n >= 500 && n < 650);
            send_random();
        end
        calm_phase = 0;
        i_valid <= 0;
        stimulus_done = 1;
    end

    initial begin
        wait (stimulus_done);
        while (heap_model.pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (heap_model.mismatch_count == 0)
            $display("PASS stable_priority_heap_queue");
        else
            $display("FAIL stable_priority_heap_queue");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL stable_priority_heap_queue");
        $finish;
    end
endmodule
